FILE: hdl/mau_pkg.sv
// Shared definitions for the modular arithmetic unit.
// Operation codes, reset modulus and the command/status structs between
// controller and datapath. No dependencies.
package mau_pkg;

	// operation codes carried in the input tuser
	localparam logic [2:0] KIND_ADD = 3'd0;
	localparam logic [2:0] KIND_SUB = 3'd1;
	localparam logic [2:0] KIND_MUL = 3'd2;
	localparam logic [2:0] KIND_DIV = 3'd3;
	localparam logic [2:0] KIND_NEG = 3'd4;
	localparam logic [2:0] KIND_EQ  = 3'd5;

	localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_SIMPLE,
		RES_ACC,
		RES_NOINV
	} res_op_t;

	typedef struct packed {
		logic    load_in;      // capture operands, start reducing operand a
		logic    div_step;     // one restoring-division step
		logic    dbl_step;     // accumulator doubling mod m
		logic    add_step;     // conditional accumulator add mod m
		logic    mode_euc;     // divisor r1, addend t1, bit from quotient
		logic    red_a_store;  // reduced operand a is ready
		logic    start_b;      // start reducing operand b
		logic    red_b_store;  // reduced operand b is ready
		logic    mul_init;     // multiply a by b
		logic    inv_init;     // multiply a by the inverse
		logic    euc_init;     // seed the extended Euclidean loop
		logic    euc_div_init; // start dividing r0 by r1
		logic    euc_update;   // shift remainders and coefficients
		res_op_t res_op;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic       r1_zero;
		logic       r0_one;
		logic [2:0] kind;
	} dp_stat_t;

endpackage

FILE: hdl/mau_datapath.sv
// Datapath of the modular arithmetic unit: modulus register, restoring
// divider, double-and-add accumulator, Euclidean registers and result.
// Depends on mau_pkg; driven by mau_ctrl commands.
module mau_datapath #(
	parameter int W = 31
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [W-1:0]      cfg_wdata,
	input  logic [2:0]        in_kind,
	input  logic [W-1:0]      in_a,
	input  logic [W-1:0]      in_b,
	input  mau_pkg::dp_cmd_t  cmd,
	output mau_pkg::dp_stat_t stat,
	output logic [W-1:0]      out_value,
	output logic              out_eq,
	output logic              out_noinv
);
	import mau_pkg::*;

	logic [W-1:0] m_q, m_eff;
	logic         m_small;
	logic [2:0]   kind_q;
	logic [W-1:0] a_q, b_q;
	logic [W-1:0] dn_q, rem_q, rem_nxt, divisor;
	logic         qbit_q, rem_ge;
	logic [W:0]   rem_sh, rem_dif;
	logic [W-1:0] acc_q, mb_q, addend, dbl_nxt, sum_nxt, t2;
	logic [W:0]   dbl, dbl_dif, sum, sum_dif, t_dif;
	logic         add_bit;
	logic [W-1:0] r0_q, r1_q, t0_q, t1_q;
	logic [W-1:0] res_val_q;
	logic         res_eq_q, res_noinv_q;
	logic [W-1:0] add_v, sub_v, neg_v, simple_v;
	logic [W:0]   s_add, s_add_dif, s_sub;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= MODULUS_RESET[W-1:0];
		end else if (cfg_wen) begin
			m_q <= cfg_wdata;
		end
	end

	// modulus zero or one behaves as one
	assign m_small = (m_q[W-1:1] == '0);
	assign m_eff   = m_small ? W'(1) : m_q;

	// restoring division, one quotient bit per step
	assign divisor = cmd.mode_euc ? r1_q : m_eff;
	assign rem_sh  = {rem_q, dn_q[W-1]};
	assign rem_dif = rem_sh - {1'b0, divisor};
	assign rem_ge  = (rem_sh >= {1'b0, divisor});
	assign rem_nxt = rem_ge ? rem_dif[W-1:0] : rem_sh[W-1:0];

	// double-and-add accumulator, every value kept below m
	assign dbl     = {acc_q, 1'b0};
	assign dbl_dif = dbl - {1'b0, m_eff};
	assign dbl_nxt = (dbl >= {1'b0, m_eff}) ? dbl_dif[W-1:0] : dbl[W-1:0];
	assign addend  = cmd.mode_euc ? t1_q : a_q;
	assign add_bit = cmd.mode_euc ? qbit_q : mb_q[W-1];
	assign sum     = {1'b0, acc_q} + {1'b0, addend};
	assign sum_dif = sum - {1'b0, m_eff};
	assign sum_nxt = (sum >= {1'b0, m_eff}) ? sum_dif[W-1:0] : sum[W-1:0];

	// next Bezout coefficient: t0 - q*t1 mod m
	assign t_dif = {1'b0, t0_q} - {1'b0, acc_q} + ((t0_q < acc_q) ? {1'b0, m_eff} : '0);
	assign t2    = t_dif[W-1:0];

	// simple operations on reduced operands, computed combinationally
	assign s_add     = {1'b0, a_q} + {1'b0, b_q};
	assign s_add_dif = s_add - {1'b0, m_eff};
	assign add_v     = (s_add >= {1'b0, m_eff}) ? s_add_dif[W-1:0] : s_add[W-1:0];
	assign s_sub     = {1'b0, a_q} - {1'b0, b_q} + ((a_q < b_q) ? {1'b0, m_eff} : '0);
	assign sub_v     = s_sub[W-1:0];
	assign neg_v     = (a_q == '0) ? '0 : (m_eff - a_q);

	always_comb begin
		unique case (kind_q)
			KIND_ADD: simple_v = add_v;
			KIND_SUB: simple_v = sub_v;
			KIND_NEG: simple_v = neg_v;
			default:  simple_v = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q <= in_kind;
			a_q    <= in_a;
			b_q    <= in_b;
		end
		if (cmd.red_a_store) a_q <= rem_nxt;
		if (cmd.red_b_store) b_q <= rem_nxt;

		// divider: a start overrides the step of the same cycle
		if (cmd.load_in) begin
			dn_q  <= in_a;
			rem_q <= '0;
		end else if (cmd.start_b) begin
			dn_q  <= b_q;
			rem_q <= '0;
		end else if (cmd.euc_div_init) begin
			dn_q  <= r0_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dn_q  <= {dn_q[W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
		if (cmd.div_step) qbit_q <= rem_ge;

		// accumulator
		if (cmd.mul_init || cmd.inv_init || cmd.euc_div_init) begin
			acc_q <= '0;
		end else if (cmd.dbl_step) begin
			acc_q <= dbl_nxt;
		end else if (cmd.add_step && add_bit) begin
			acc_q <= sum_nxt;
		end
		if (cmd.mul_init) begin
			mb_q <= b_q;
		end else if (cmd.inv_init) begin
			mb_q <= t0_q;
		end else if (cmd.add_step && !cmd.mode_euc) begin
			mb_q <= {mb_q[W-2:0], 1'b0};
		end

		// extended Euclidean registers
		if (cmd.euc_init) begin
			r0_q <= m_eff;
			r1_q <= b_q;
			t0_q <= '0;
			t1_q <= m_small ? '0 : W'(1);
		end else if (cmd.euc_update) begin
			r0_q <= r1_q;
			r1_q <= rem_q;
			t0_q <= t1_q;
			t1_q <= t2;
		end

		unique case (cmd.res_op)
			RES_SIMPLE: begin
				res_val_q   <= simple_v;
				res_eq_q    <= (kind_q == KIND_EQ) && (a_q == b_q);
				res_noinv_q <= 1'b0;
			end
			RES_ACC: begin
				// take the final add of the same cycle
				res_val_q   <= add_bit ? sum_nxt : acc_q;
				res_eq_q    <= 1'b0;
				res_noinv_q <= 1'b0;
			end
			RES_NOINV: begin
				res_val_q   <= '0;
				res_eq_q    <= 1'b0;
				res_noinv_q <= 1'b1;
			end
			default: begin
			end
		endcase

		if (cmd.out_load) begin
			out_value <= res_val_q;
			out_eq    <= res_eq_q;
			out_noinv <= res_noinv_q;
		end
	end

	assign stat.r1_zero = (r1_q == '0);
	assign stat.r0_one  = (r0_q == W'(1));
	assign stat.kind    = kind_q;

endmodule

FILE: hdl/mau_ctrl.sv
// Controller of the modular arithmetic unit: sequences reduction,
// multiplication and the inverse loop, and owns the handshakes.
// Depends on mau_pkg; commands mau_datapath.
module mau_ctrl #(
	parameter int W = 31
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  mau_pkg::dp_stat_t stat,
	output mau_pkg::dp_cmd_t  cmd
);
	import mau_pkg::*;

	localparam int CW = (W > 1) ? $clog2(W) : 1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RED_A,
		S_RED_B,
		S_DISPATCH,
		S_MUL_DBL,
		S_MUL_ADD,
		S_EUC_CHK,
		S_EUC_DIV,
		S_EUC_ADD,
		S_EUC_UPD,
		S_DONE
	} state_t;

	state_t        state_q, state_nxt;
	logic [CW-1:0] cnt_q, cnt_nxt;
	logic          out_valid_q;
	logic          last;

	assign last      = (cnt_q == '0);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		cnt_nxt   = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					cnt_nxt     = CW'(W - 1);
					state_nxt   = S_RED_A;
				end
			end
			S_RED_A: begin
				cmd.div_step = 1'b1;
				if (last) begin
					cmd.red_a_store = 1'b1;
					cmd.start_b     = 1'b1;
					cnt_nxt         = CW'(W - 1);
					state_nxt       = S_RED_B;
				end else begin
					cnt_nxt = cnt_q - 1'b1;
				end
			end
			S_RED_B: begin
				cmd.div_step = 1'b1;
				if (last) begin
					cmd.red_b_store = 1'b1;
					state_nxt       = S_DISPATCH;
				end else begin
					cnt_nxt = cnt_q - 1'b1;
				end
			end
			S_DISPATCH: begin
				if (stat.kind == KIND_MUL) begin
					cmd.mul_init = 1'b1;
					cnt_nxt      = CW'(W - 1);
					state_nxt    = S_MUL_DBL;
				end else if (stat.kind == KIND_DIV) begin
					cmd.euc_init = 1'b1;
					state_nxt    = S_EUC_CHK;
				end else begin
					cmd.res_op = RES_SIMPLE;
					state_nxt  = S_DONE;
				end
			end
			S_MUL_DBL: begin
				cmd.dbl_step = 1'b1;
				state_nxt    = S_MUL_ADD;
			end
			S_MUL_ADD: begin
				cmd.add_step = 1'b1;
				if (last) begin
					cmd.res_op = RES_ACC;
					state_nxt  = S_DONE;
				end else begin
					cnt_nxt   = cnt_q - 1'b1;
					state_nxt = S_MUL_DBL;
				end
			end
			S_EUC_CHK: begin
				priority if (stat.r1_zero && stat.r0_one) begin
					cmd.inv_init = 1'b1;
					cnt_nxt      = CW'(W - 1);
					state_nxt    = S_MUL_DBL;
				end else if (stat.r1_zero) begin
					cmd.res_op = RES_NOINV;
					state_nxt  = S_DONE;
				end else begin
					cmd.euc_div_init = 1'b1;
					cnt_nxt          = CW'(W - 1);
					state_nxt        = S_EUC_DIV;
				end
			end
			S_EUC_DIV: begin
				// quotient bit and accumulator doubling in parallel
				cmd.mode_euc = 1'b1;
				cmd.div_step = 1'b1;
				cmd.dbl_step = 1'b1;
				state_nxt    = S_EUC_ADD;
			end
			S_EUC_ADD: begin
				cmd.mode_euc = 1'b1;
				cmd.add_step = 1'b1;
				if (last) begin
					state_nxt = S_EUC_UPD;
				end else begin
					cnt_nxt   = cnt_q - 1'b1;
					state_nxt = S_EUC_DIV;
				end
			end
			S_EUC_UPD: begin
				cmd.euc_update = 1'b1;
				state_nxt      = S_EUC_CHK;
			end
			S_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/modular_arithmetic_unit.sv
// Modular arithmetic unit: add, subtract, multiply, divide, negate and
// equality test in the integers modulo a programmable modulus (zero or
// one acts as one). One item is worked at a time; a finished result sits
// in the output register while the next item is taken. Both operands are
// first reduced by a shared restoring divider, one bit a cycle; for add,
// subtract, negate and equal test the result is then registered and shown,
// and the next item can be taken in the same cycle that it is shown.
// Multiply then runs a double-and-add loop. Divide runs the extended
// Euclidean loop, each round a bit-serial division fused with a multiply
// (at most about 1.44*W rounds), then a final multiply.
// Depends on mau_pkg, mau_ctrl and mau_datapath.
module modular_arithmetic_unit #(
	parameter int VALUE_WIDTH = 31
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_wen,
	input  logic [VALUE_WIDTH-1:0]                   cfg_wdata,  // modulus
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]       s_tdata,    // operand_a, operand_b
	input  logic [2:0]                               s_tuser,    // kind
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	output logic [((VALUE_WIDTH+7)/8)*8-1:0]         m_tdata,    // value
	output logic [1:0]                               m_tuser     // is_equal, no_inverse
);
	import mau_pkg::*;

	localparam int W      = VALUE_WIDTH;
	localparam int OUT_DW = ((VALUE_WIDTH + 7) / 8) * 8;

	dp_cmd_t      cmd;
	dp_stat_t     stat;
	logic [W-1:0] out_value;
	logic         out_eq, out_noinv;

	mau_ctrl #(
		.W(W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mau_datapath #(
		.W(W)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_kind   (s_tuser),
		.in_a      (s_tdata[W-1:0]),
		.in_b      (s_tdata[2*W-1:W]),
		.cmd       (cmd),
		.stat      (stat),
		.out_value (out_value),
		.out_eq    (out_eq),
		.out_noinv (out_noinv)
	);

	assign m_tdata = OUT_DW'(out_value);
	assign m_tuser = {out_noinv, out_eq};

endmodule

FILE: tb/modular_arithmetic_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for modular_arithmetic_unit: a directed table, then random items
// over several moduli, each checked against a fixed value or a behavioural predictor.
// Depends on mau_pkg and the RTL of modular_arithmetic_unit only.
module modular_arithmetic_unit_tb;
	import mau_pkg::*;

	localparam int VW = 31;
	localparam logic [VW-1:0] OPER_MAX = {VW{1'b1}};
	// kinds outside the defined set, expected to give all-zero results
	localparam logic [2:0] KIND_RSVD6 = 3'd6;
	localparam logic [2:0] KIND_RSVD7 = 3'd7;
	localparam int PHASE_ITEMS = 200;

	typedef struct packed {
		logic [VW-1:0] value;
		logic          is_equal;
		logic          no_inverse;
	} residue_t;

	typedef struct {
		logic [2:0]    kind;
		logic [VW-1:0] a;
		logic [VW-1:0] b;
		bit            fixed;
		residue_t      want;
	} stim_row_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_wen = 1'b0;
	logic [VW-1:0] cfg_wdata = '0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [63:0]   s_tdata = '0;   // operand_a, operand_b
	logic [2:0]    s_tuser = '0;   // kind
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [31:0]   m_tdata;        // value
	logic [1:0]    m_tuser;        // is_equal, no_inverse

	residue_t      residues_due[$];
	logic [VW-1:0] ring_modulus = MODULUS_RESET[VW-1:0];
	int            mismatches = 0;
	bit            steady_sender = 1'b0;

	modular_arithmetic_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#(64'd300_000_000);
		$display("modular_arithmetic_unit_tb: FAIL");
		$finish;
	end

	function automatic residue_t predict_residue(logic [2:0] kind, logic [VW-1:0] a_in,
			logic [VW-1:0] b_in, logic [VW-1:0] mod_reg);
		longint m, a, b, r0, r1, s0, s1, q, tmp;
		residue_t r;
		m = (mod_reg < 2) ? 1 : longint'(mod_reg);
		a = longint'(a_in) % m;
		b = longint'(b_in) % m;
		r = '0;
		case (kind)
			KIND_ADD: r.value = VW'((a + b) % m);
			KIND_SUB: r.value = VW'((a + m - b) % m);
			KIND_MUL: r.value = VW'((a * b) % m);
			KIND_DIV: begin
				// extended Euclid on (m, b); s0 tracks the coefficient of b
				r0 = m;
				r1 = b;
				s0 = 0;
				s1 = 1;
				while (r1 != 0) begin
					q = r0 / r1;
					tmp = r0 - q * r1;
					r0 = r1;
					r1 = tmp;
					tmp = s0 - q * s1;
					s0 = s1;
					s1 = tmp;
				end
				if (r0 != 1) begin
					r.no_inverse = 1'b1;
				end else begin
					s0 = ((s0 % m) + m) % m;
					r.value = VW'((a * s0) % m);
				end
			end
			KIND_NEG: r.value = VW'((m - a) % m);
			KIND_EQ:  r.is_equal = (a == b);
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_sender || r < 40)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 20);
		return $urandom_range(30, 150);
	endfunction

	// Offer one item and hold it until taken; queue its expected result on acceptance.
	task automatic offer_item(logic [2:0] kind, logic [VW-1:0] a, logic [VW-1:0] b,
			residue_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, b, a};
		s_tuser  <= kind;
		do @(posedge clk); while (!s_tready);
		residues_due.push_back(want);
	endtask

	task automatic write_modulus(logic [VW-1:0] m);
		while (residues_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_wen      <= 1'b0;
		ring_modulus  = m;
	endtask

	function automatic stim_row_t row(logic [2:0] kind, logic [VW-1:0] a, logic [VW-1:0] b,
			bit fixed, logic [VW-1:0] value, logic is_equal, logic no_inverse);
		stim_row_t s;
		s.kind = kind;
		s.a = a;
		s.b = b;
		s.fixed = fixed;
		s.want = '{value, is_equal, no_inverse};
		return s;
	endfunction

	function automatic logic [VW-1:0] pick_operand(logic [VW-1:0] mod_reg);
		logic [VW-1:0] m;
		m = (mod_reg < 2) ? VW'(1) : mod_reg;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return OPER_MAX;
			2: return m - VW'(1);
			3: return m;
			4: return VW'($urandom_range(0, 15));
			5: return m + VW'($urandom_range(1, 3));
			default: return VW'($urandom);
		endcase
	endfunction

	function automatic logic [2:0] pick_kind();
		if ($urandom_range(0, 39) == 0)
			return $urandom_range(0, 1) ? KIND_RSVD6 : KIND_RSVD7;
		return 3'($urandom_range(0, 5));
	endfunction

	// Result side: check each accepted item, then choose the next ready level.
	initial begin : result_sink
		int       run_left;
		int       hold_left;
		int       seen;
		bit       ready_level;
		residue_t want;
		run_left = 0;
		hold_left = 0;
		seen = 0;
		ready_level = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				seen++;
				if (residues_due.size() == 0) begin
					report_mismatch("result with nothing outstanding", m_tdata, 0);
				end else begin
					want = residues_due.pop_front();
					if (m_tdata !== {1'b0, want.value})
						report_mismatch("value", m_tdata, want.value);
					if (m_tuser[0] !== want.is_equal)
						report_mismatch("is_equal", m_tuser[0], want.is_equal);
					if (m_tuser[1] !== want.no_inverse)
						report_mismatch("no_inverse", m_tuser[1], want.no_inverse);
				end
				// hold off long enough for the input side to back up
				if (seen == 600 || seen == 1700)
					hold_left = 2500;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					ready_level = ($urandom_range(0, 9) < 7);
					if (ready_level)
						run_left = ($urandom_range(0, 19) == 0) ?
							$urandom_range(20, 100) : $urandom_range(1, 8);
					else
						run_left = ($urandom_range(0, 19) == 0) ?
							$urandom_range(20, 120) : $urandom_range(1, 4);
				end
				run_left--;
				m_tready <= ready_level;
			end
		end
	end

	initial begin : stimulus
		stim_row_t     directed[$];
		logic [VW-1:0] moduli[$];
		logic [2:0]    kind;
		logic [VW-1:0] a;
		logic [VW-1:0] b;
		residue_t      want;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset modulus 1000000007; 2^31-1 reduces to 147483633
		directed.push_back(row(KIND_ADD, 0, 0, 1, 0, 0, 0));
		directed.push_back(row(KIND_ADD, OPER_MAX, OPER_MAX, 0, 0, 0, 0));
		directed.push_back(row(KIND_ADD, 1000000006, 1, 1, 0, 0, 0));
		directed.push_back(row(KIND_SUB, 0, 1, 1, 1000000006, 0, 0));
		directed.push_back(row(KIND_SUB, OPER_MAX, OPER_MAX, 1, 0, 0, 0));
		directed.push_back(row(KIND_SUB, 3, OPER_MAX, 0, 0, 0, 0));
		directed.push_back(row(KIND_MUL, OPER_MAX, OPER_MAX, 0, 0, 0, 0));
		directed.push_back(row(KIND_MUL, 1000000006, 1000000006, 1, 1, 0, 0));
		directed.push_back(row(KIND_MUL, OPER_MAX, 0, 1, 0, 0, 0));
		directed.push_back(row(KIND_DIV, 1, 0, 1, 0, 0, 1));
		directed.push_back(row(KIND_DIV, OPER_MAX, 1000000007, 1, 0, 0, 1));
		directed.push_back(row(KIND_DIV, 6, 3, 1, 2, 0, 0));
		directed.push_back(row(KIND_DIV, 1, 2, 1, 500000004, 0, 0));
		directed.push_back(row(KIND_DIV, OPER_MAX, OPER_MAX, 1, 1, 0, 0));
		directed.push_back(row(KIND_DIV, 0, 5, 1, 0, 0, 0));
		directed.push_back(row(KIND_NEG, 0, OPER_MAX, 1, 0, 0, 0));
		directed.push_back(row(KIND_NEG, 1, 0, 1, 1000000006, 0, 0));
		directed.push_back(row(KIND_NEG, OPER_MAX, 7, 0, 0, 0, 0));
		directed.push_back(row(KIND_EQ, 1000000008, 1, 1, 0, 1, 0));
		directed.push_back(row(KIND_EQ, 0, OPER_MAX, 1, 0, 0, 0));
		directed.push_back(row(KIND_EQ, OPER_MAX, 147483633, 1, 0, 1, 0));
		directed.push_back(row(KIND_RSVD6, OPER_MAX, OPER_MAX, 1, 0, 0, 0));
		directed.push_back(row(KIND_RSVD7, 1, 2, 1, 0, 0, 0));

		foreach (directed[i]) begin
			want = directed[i].fixed ? directed[i].want :
				predict_residue(directed[i].kind, directed[i].a, directed[i].b, ring_modulus);
			offer_item(directed[i].kind, directed[i].a, directed[i].b, want);
		end
		s_tvalid <= 1'b0;

		// extremes first, zero and one behave as modulus one
		moduli = '{31'd2, OPER_MAX, 31'd1, 31'd0, 31'h4000_0000, 31'd360,
			VW'($urandom_range(3, 64)), VW'($urandom_range(2, OPER_MAX)),
			VW'($urandom_range(2, OPER_MAX)), MODULUS_RESET[VW-1:0]};
		foreach (moduli[p]) begin
			write_modulus(moduli[p]);
			steady_sender = ($urandom_range(0, 3) == 0);
			repeat (PHASE_ITEMS) begin
				kind = pick_kind();
				a = pick_operand(ring_modulus);
				b = pick_operand(ring_modulus);
				offer_item(kind, a, b, predict_residue(kind, a, b, ring_modulus));
			end
			s_tvalid <= 1'b0;
		end

		while (residues_due.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("modular_arithmetic_unit_tb: PASS");
		else
			$display("modular_arithmetic_unit_tb: FAIL");
		$finish;
	end

endmodule
